### sv/sfs_pkg.sv
// Package for the sortable FIFO with search.
// Holds request and status codes, sequencer states and the command and status structs.
// Depends on nothing; every other file refers to it by scoped names.
package sfs_pkg;

  // Default sizes handed to the top level.
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed payload widths of the channels.
  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int FRONT_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Request codes carried in req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_QUERY = 3'd3,
    REQ_SORT  = 3'd4
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_Q_RD,
    S_Q_CMP,
    S_SRT_START,
    S_SRT_LOAD,
    S_SRT_RD,
    S_SRT_CMP,
    S_SRT_END,
    S_FETCH,
    S_RESP
  } state_t;

  // Offset from the head used to form the ring address.
  typedef enum logic [1:0] {
    OFS_K,
    OFS_COUNT,
    OFS_ONE,
    OFS_ZERO
  } ofs_sel_t;

  // Source of the memory write data.
  typedef enum logic [1:0] {
    WS_WORD,
    WS_CARRY,
    WS_RDATA
  } wr_src_t;

  // Source of the memory write address.
  typedef enum logic [1:0] {
    WA_SLOT,
    WA_PREV,
    WA_LAST
  } wr_addr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     rd_en;
    logic     wr_en;
    wr_src_t  wr_src;
    wr_addr_t wr_addr;
    ofs_sel_t ofs_sel;
    logic     k_clr;
    logic     k_inc;
    logic     pass_clr;
    logic     pass_inc;
    logic     swap_clr;
    logic     swap_set;
    logic     carry_ld;
    logic     found_clr;
    logic     found_set;
    logic     status_ld;
    status_t  status_val;
    logic     count_inc;
    logic     count_dec;
    logic     head_pop;
    logic     out_ld;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             empty;
    logic             full;
    logic             cnt_one;
    logic             k_last;
    logic             pass_last;
    logic             gt;
    logic             eq;
    logic             swapped;
    logic             out_free;
  } stat_t;

endpackage

### sv/sfs_in_if.sv
// Request channel interface: valid, ready and one request word.
// Depends on sfs_pkg for the payload widths.
interface sfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfs_pkg::REQ_W-1:0]     req_type;
  logic [sfs_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

### sv/sfs_out_if.sv
// Result channel interface: valid, ready and one result word.
// Depends on sfs_pkg for the payload widths.
interface sfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [sfs_pkg::FRONT_W-1:0]   front_word;
  logic                          found;
  logic [sfs_pkg::COUNT_W-1:0]   entry_count;
  logic [sfs_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output front_word, output found, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input front_word, input found, input entry_count,
                  input status, output ready);
endinterface

### sv/sortable_fifo_with_search.sv
// Sortable FIFO with search. Push, pop, peek and unknown requests pass through the execute,
// fetch and result states before the next acceptance; a query adds a read and a compare state
// per entry walked; a sort makes up to n passes over n entries, with a read and a compare
// per entry, all through the single read port of the ring memory. A result waiting in the output
// register does not block the next acceptance; that request then holds in its result state
// until the register frees. Synchronous reset empties the queue; ring contents stay.
module sortable_fifo_with_search #(
  parameter int DEPTH      = sfs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sfs_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sfs_in_if.sink     in_ch,
  sfs_out_if.source  out_ch
);

  sfs_pkg::cmd_t  cmd;
  sfs_pkg::stat_t stat;

  sfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfs_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_ch.req_type),
    .in_value        (in_ch.value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_front_word  (out_ch.front_word),
    .out_found       (out_ch.found),
    .out_entry_count (out_ch.entry_count),
    .out_status      (out_ch.status)
  );

  // One request at a time: no new word right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in work");

  // A dropped push reports a full queue.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == sfs_pkg::ST_FULL)
      |-> (out_ch.entry_count == sfs_pkg::COUNT_W'(DEPTH)))
    else $error("full status with wrong entry count");

  // A match can only come from a query on a non-empty queue.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.found) |-> (out_ch.status == sfs_pkg::ST_OK))
    else $error("found flag with non-ok status");

endmodule

### sv/sfs_ctrl.sv
// Controller of the sortable FIFO: sequences each request over the datapath.
// Depends on sfs_pkg for states, codes and the command and status structs.
module sfs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sfs_pkg::stat_t stat,
  output sfs_pkg::cmd_t  cmd
);

  sfs_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfs_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sfs_pkg::S_EXEC;
      end
      sfs_pkg::S_EXEC: begin
        state_nxt = sfs_pkg::S_FETCH;
        case (stat.req)
          sfs_pkg::REQ_QUERY: begin
            if (!stat.empty) state_nxt = sfs_pkg::S_Q_RD;
          end
          sfs_pkg::REQ_SORT: begin
            if (!stat.empty && !stat.cnt_one) state_nxt = sfs_pkg::S_SRT_START;
          end
          default: state_nxt = sfs_pkg::S_FETCH;
        endcase
      end
      sfs_pkg::S_Q_RD:  state_nxt = sfs_pkg::S_Q_CMP;
      sfs_pkg::S_Q_CMP: begin
        if (stat.eq || stat.k_last) state_nxt = sfs_pkg::S_FETCH;
        else                        state_nxt = sfs_pkg::S_Q_RD;
      end
      sfs_pkg::S_SRT_START: state_nxt = sfs_pkg::S_SRT_LOAD;
      sfs_pkg::S_SRT_LOAD:  state_nxt = sfs_pkg::S_SRT_RD;
      sfs_pkg::S_SRT_RD:    state_nxt = sfs_pkg::S_SRT_CMP;
      sfs_pkg::S_SRT_CMP: begin
        if (stat.k_last) state_nxt = sfs_pkg::S_SRT_END;
        else             state_nxt = sfs_pkg::S_SRT_RD;
      end
      sfs_pkg::S_SRT_END: begin
        if (!stat.swapped || stat.pass_last) state_nxt = sfs_pkg::S_FETCH;
        else                                 state_nxt = sfs_pkg::S_SRT_START;
      end
      sfs_pkg::S_FETCH: state_nxt = sfs_pkg::S_RESP;
      sfs_pkg::S_RESP: begin
        if (stat.out_free) state_nxt = sfs_pkg::S_IDLE;
      end
      default: state_nxt = sfs_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd            = '0;
    cmd.wr_src     = sfs_pkg::WS_WORD;
    cmd.wr_addr    = sfs_pkg::WA_SLOT;
    cmd.ofs_sel    = sfs_pkg::OFS_K;
    cmd.status_val = sfs_pkg::ST_OK;
    in_ready       = 1'b0;
    case (state_r)
      sfs_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      sfs_pkg::S_EXEC: begin
        cmd.status_ld = 1'b1;
        cmd.found_clr = 1'b1;
        cmd.k_clr     = 1'b1;
        cmd.pass_clr  = 1'b1;
        case (stat.req)
          sfs_pkg::REQ_PUSH: begin
            if (stat.full) begin
              cmd.status_val = sfs_pkg::ST_FULL;
            end else begin
              cmd.ofs_sel   = sfs_pkg::OFS_COUNT;
              cmd.wr_en     = 1'b1;
              cmd.wr_src    = sfs_pkg::WS_WORD;
              cmd.wr_addr   = sfs_pkg::WA_SLOT;
              cmd.count_inc = 1'b1;
            end
          end
          sfs_pkg::REQ_POP: begin
            if (stat.empty) begin
              cmd.status_val = sfs_pkg::ST_EMPTY;
            end else begin
              cmd.ofs_sel   = sfs_pkg::OFS_ONE;
              cmd.head_pop  = 1'b1;
              cmd.count_dec = 1'b1;
            end
          end
          sfs_pkg::REQ_PEEK, sfs_pkg::REQ_QUERY, sfs_pkg::REQ_SORT: begin
            if (stat.empty) cmd.status_val = sfs_pkg::ST_EMPTY;
          end
          default: cmd.status_val = sfs_pkg::ST_OK;
        endcase
      end
      sfs_pkg::S_Q_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.ofs_sel = sfs_pkg::OFS_K;
      end
      sfs_pkg::S_Q_CMP: begin
        if (stat.eq) cmd.found_set = 1'b1;
        else         cmd.k_inc     = !stat.k_last;
      end
      // First read of a pass fills the carry.
      sfs_pkg::S_SRT_START: begin
        cmd.rd_en    = 1'b1;
        cmd.ofs_sel  = sfs_pkg::OFS_K;
        cmd.swap_clr = 1'b1;
        cmd.k_inc    = 1'b1;
      end
      sfs_pkg::S_SRT_LOAD: begin
        cmd.carry_ld = 1'b1;
      end
      sfs_pkg::S_SRT_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.ofs_sel = sfs_pkg::OFS_K;
      end
      // The larger word travels on in the carry; the smaller one lands behind it.
      sfs_pkg::S_SRT_CMP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = sfs_pkg::WA_PREV;
        if (stat.gt) begin
          cmd.wr_src   = sfs_pkg::WS_RDATA;
          cmd.swap_set = 1'b1;
        end else begin
          cmd.wr_src   = sfs_pkg::WS_CARRY;
          cmd.carry_ld = 1'b1;
        end
        cmd.k_inc = !stat.k_last;
      end
      sfs_pkg::S_SRT_END: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_addr  = sfs_pkg::WA_LAST;
        cmd.wr_src   = sfs_pkg::WS_CARRY;
        cmd.k_clr    = 1'b1;
        cmd.pass_inc = 1'b1;
      end
      sfs_pkg::S_FETCH: begin
        cmd.rd_en   = 1'b1;
        cmd.ofs_sel = sfs_pkg::OFS_ZERO;
      end
      sfs_pkg::S_RESP: begin
        cmd.out_ld = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### sv/sfs_dpath.sv
// Datapath of the sortable FIFO: ring memory, pointers, counters and result register.
// Depends on sfs_pkg for codes and the command and status structs.
module sfs_dpath #(
  parameter int DEPTH      = sfs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sfs_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfs_pkg::cmd_t                  cmd,
  output sfs_pkg::stat_t                 stat,
  input  logic [sfs_pkg::REQ_W-1:0]      in_req_type,
  input  logic [sfs_pkg::VALUE_W-1:0]    in_value,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [sfs_pkg::FRONT_W-1:0]    out_front_word,
  output logic                           out_found,
  output logic [sfs_pkg::COUNT_W-1:0]    out_entry_count,
  output logic [sfs_pkg::STATUS_W-1:0]   out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]            head_r, k_r, rd_slot_r, prev_slot_r;
  logic [CW-1:0]            count_r, pass_r;
  logic                     swapped_r, found_r;
  sfs_pkg::status_t         status_r;
  logic [sfs_pkg::REQ_W-1:0] req_r;
  logic [DATA_WIDTH-1:0]    word_r, carry_r, rdata_r;

  logic                     out_valid_r, out_found_r;
  logic [sfs_pkg::FRONT_W-1:0]  out_front_r;
  logic [sfs_pkg::COUNT_W-1:0]  out_count_r;
  logic [sfs_pkg::STATUS_W-1:0] out_status_r;

  logic [AW-1:0]         ofs, slot, wr_addr;
  logic [AW:0]           sum;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  empty;

  // Ring address: head plus offset, wrapped once.
  always_comb begin
    case (cmd.ofs_sel)
      sfs_pkg::OFS_K:     ofs = k_r;
      sfs_pkg::OFS_COUNT: ofs = count_r[AW-1:0];
      sfs_pkg::OFS_ONE:   ofs = AW'(1);
      default:            ofs = '0;
    endcase
    sum  = {1'b0, head_r} + {1'b0, ofs};
    slot = (sum >= DEPTH_A) ? AW'(sum - DEPTH_A) : sum[AW-1:0];
  end

  // Write address and data selection.
  always_comb begin
    case (cmd.wr_addr)
      sfs_pkg::WA_PREV: wr_addr = prev_slot_r;
      sfs_pkg::WA_LAST: wr_addr = rd_slot_r;
      default:          wr_addr = slot;
    endcase
    case (cmd.wr_src)
      sfs_pkg::WS_CARRY: wr_data = carry_r;
      sfs_pkg::WS_RDATA: wr_data = rdata_r;
      default:           wr_data = word_r;
    endcase
  end

  // Ring memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rdata_r <= mem[slot];
  end

  // Read address history for the sort write-back.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_slot_r   <= slot;
      prev_slot_r <= rd_slot_r;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.head_pop) head_r <= slot;
      if (cmd.count_inc)      count_r <= count_r + CW'(1);
      else if (cmd.count_dec) count_r <= count_r - CW'(1);
    end
  end

  // Request capture, walk counters and flags.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      word_r <= DATA_WIDTH'(in_value);
    end
    if (cmd.k_clr)      k_r <= '0;
    else if (cmd.k_inc) k_r <= k_r + AW'(1);
    if (cmd.pass_clr)      pass_r <= '0;
    else if (cmd.pass_inc) pass_r <= pass_r + CW'(1);
    if (cmd.swap_clr)      swapped_r <= 1'b0;
    else if (cmd.swap_set) swapped_r <= 1'b1;
    if (cmd.found_clr)      found_r <= 1'b0;
    else if (cmd.found_set) found_r <= 1'b1;
    if (cmd.carry_ld)  carry_r  <= rdata_r;
    if (cmd.status_ld) status_r <= cmd.status_val;
  end

  assign empty = (count_r == '0);

  // Status to the controller.
  always_comb begin
    stat.req       = req_r;
    stat.empty     = empty;
    stat.full      = (count_r == DEPTH_C);
    stat.cnt_one   = (count_r == CW'(1));
    stat.k_last    = ((CW'(k_r) + CW'(1)) == count_r);
    stat.pass_last = ((pass_r + CW'(1)) == count_r);
    stat.gt        = (carry_r > rdata_r);
    stat.eq        = (rdata_r == word_r);
    stat.swapped   = swapped_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

  // Result register; the front word reads as zero on an empty queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_front_r  <= empty ? '0 : sfs_pkg::FRONT_W'(rdata_r);
      out_found_r  <= found_r;
      out_count_r  <= sfs_pkg::COUNT_W'(count_r);
      out_status_r <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_word  = out_front_r;
  assign out_found       = out_found_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

endmodule

### verif/sortable_fifo_with_search_tb.sv
`timescale 1ns / 1ps
// Testbench for sortable_fifo_with_search: drives push, pop, peek, query, sort and ignored requests
// and checks every result word against a predictor of the ring kept in a scoreboard class.
// Depends on sfs_pkg, sfs_in_if, sfs_out_if and the sortable_fifo_with_search module.

module sortable_fifo_with_search_tb;

  localparam int QDEPTH = sfs_pkg::DEPTH_DEF;
  localparam int RANDOM_WORDS = 1800;
  localparam int DRAIN_EVERY = 450;
  localparam int SETTLE_CYCLES = 40;

  // Request codes the block ignores.
  localparam logic [sfs_pkg::REQ_W-1:0] REQ_RESERVED_FIRST = 3'd5;
  localparam logic [sfs_pkg::REQ_W-1:0] REQ_RESERVED_LAST  = 3'd7;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } traffic_mode_t;

  typedef struct packed {
    logic [sfs_pkg::FRONT_W-1:0]  front_word;
    logic                         found;
    logic [sfs_pkg::COUNT_W-1:0]  entry_count;
    sfs_pkg::status_t             status;
  } fifo_result_t;

  // Predicts the queue contents and keeps the results still owed by the block.
  class fifo_scoreboard;
    logic [sfs_pkg::VALUE_W-1:0] ring [QDEPTH];
    int unsigned head_pos;
    int unsigned held;
    fifo_result_t owed_q[$];
    int unsigned mismatches;

    function new();
      head_pos   = 0;
      held       = 0;
      mismatches = 0;
    endfunction

    function int unsigned slot(int unsigned ofs);
      return (head_pos + ofs) % QDEPTH;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Ascending bubble sort from front to back, stopping after a pass with no swap.
    function void sort_held();
      logic [sfs_pkg::VALUE_W-1:0] t;
      bit swapped;
      int unsigned a;
      int unsigned b;
      for (int unsigned p = 0; p < held; p++) begin
        swapped = 1'b0;
        for (int unsigned k = 0; k + 1 < held; k++) begin
          a = slot(k);
          b = slot(k + 1);
          if (ring[a] > ring[b]) begin
            t       = ring[a];
            ring[a] = ring[b];
            ring[b] = t;
            swapped = 1'b1;
          end
        end
        if (!swapped) break;
      end
    endfunction

    // Applies one accepted request and records the result it must produce.
    function void note_request(logic [sfs_pkg::REQ_W-1:0] req,
                               logic [sfs_pkg::VALUE_W-1:0] val);
      fifo_result_t r;
      r.found  = 1'b0;
      r.status = sfs_pkg::ST_OK;
      case (req)
        sfs_pkg::REQ_PUSH: begin
          if (held >= QDEPTH) begin
            r.status = sfs_pkg::ST_FULL;
          end else begin
            ring[slot(held)] = val;
            held++;
          end
        end
        sfs_pkg::REQ_POP: begin
          if (held == 0) begin
            r.status = sfs_pkg::ST_EMPTY;
          end else begin
            head_pos = slot(1);
            held--;
          end
        end
        sfs_pkg::REQ_PEEK: begin
          if (held == 0) r.status = sfs_pkg::ST_EMPTY;
        end
        sfs_pkg::REQ_QUERY: begin
          if (held == 0) begin
            r.status = sfs_pkg::ST_EMPTY;
          end else begin
            for (int unsigned k = 0; k < held; k++) begin
              if (ring[slot(k)] == val) r.found = 1'b1;
            end
          end
        end
        sfs_pkg::REQ_SORT: begin
          if (held == 0) r.status = sfs_pkg::ST_EMPTY;
          else sort_held();
        end
        default: begin
        end
      endcase
      r.front_word  = (held == 0) ? '0 : ring[head_pos];
      r.entry_count = sfs_pkg::COUNT_W'(held);
      owed_q.push_back(r);
    endfunction

    // Compares one result word with the oldest one owed.
    function void check_result(fifo_result_t got);
      fifo_result_t want;
      if (owed_q.size() == 0) begin
        $error("result word arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (got.front_word !== want.front_word) begin
        $error("front_word: expected %h, actual %h", want.front_word, got.front_word);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sfs_in_if  in_ch ();
  sfs_out_if out_ch ();

  fifo_scoreboard book = new();

  sortable_fifo_with_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watch both channels; a request is noted before a result is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        book.note_request(in_ch.req_type, in_ch.value);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        book.check_result({out_ch.front_word, out_ch.found, out_ch.entry_count,
                           out_ch.status});
      end
    end
  end

  // The receiver switches between stall patterns of random length.
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 2) == 0);
      default: out_ch.ready <= (rx_tick[2:0] < 3'd3);
    endcase
  end

  // Offers one word and holds it until the block takes it.
  task automatic send_word(logic [sfs_pkg::REQ_W-1:0] req, logic [sfs_pkg::VALUE_W-1:0] val);
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.value    <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic idle_for(int unsigned n);
    if (n == 0) return;
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Holds off the sender until every owed result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Small values make queries hit; extremes and full-range values cover every bit.
  function automatic logic [sfs_pkg::VALUE_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 15);
    if (roll < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // Request mix leans toward pushes or pops so the queue swings between full and empty.
  function automatic logic [sfs_pkg::REQ_W-1:0] pick_request(traffic_mode_t mode);
    int unsigned roll;
    int unsigned t_push;
    int unsigned t_pop;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        t_push = 55;
        t_pop  = 65;
      end
      MODE_DRAIN: begin
        t_push = 20;
        t_pop  = 70;
      end
      default: begin
        t_push = 35;
        t_pop  = 65;
      end
    endcase
    if (roll < t_push) return sfs_pkg::REQ_PUSH;
    if (roll < t_pop) return sfs_pkg::REQ_POP;
    if (roll < t_pop + 7) return sfs_pkg::REQ_PEEK;
    if (roll < t_pop + 22) return sfs_pkg::REQ_QUERY;
    if (roll < t_pop + 29) return sfs_pkg::REQ_SORT;
    return sfs_pkg::REQ_W'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
  endfunction

  // Main sequence: reset, directed words, random traffic, then drain and report.
  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned mode_left;
    traffic_mode_t mode;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = '0;
    in_ch.value    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every request but push on an empty queue, including an ignored code.
    send_word(sfs_pkg::REQ_PEEK, 32'h0);
    send_word(sfs_pkg::REQ_POP, 32'h0);
    send_word(sfs_pkg::REQ_QUERY, 32'h0);
    send_word(sfs_pkg::REQ_SORT, 32'h0);
    send_word(REQ_RESERVED_LAST, 32'hFFFF_FFFF);

    // Fill to the top with extremes and a descending run, then push once more.
    send_word(sfs_pkg::REQ_PUSH, 32'hFFFF_FFFF);
    send_word(sfs_pkg::REQ_PUSH, 32'h0000_0000);
    send_word(sfs_pkg::REQ_PUSH, 32'hA5A5_A5A5);
    send_word(sfs_pkg::REQ_PUSH, 32'h5A5A_5A5A);
    for (int i = 0; i < QDEPTH - 4; i++) begin
      send_word(sfs_pkg::REQ_PUSH, 32'(100 - 7 * i));
    end
    send_word(sfs_pkg::REQ_PUSH, 32'h8000_0000);
    send_word(sfs_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    send_word(sfs_pkg::REQ_QUERY, 32'hDEAD_BEEF);
    send_word(sfs_pkg::REQ_SORT, 32'h0);
    send_word(sfs_pkg::REQ_PEEK, 32'h0);
    send_word(REQ_RESERVED_FIRST, 32'h0);
    wait_drained();

    // Random bursts with random gaps; the traffic mode changes now and then.
    sent      = 0;
    mode      = MODE_FILL;
    mode_left = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int unsigned b = 0; b < burst && sent < RANDOM_WORDS; b++) begin
        if (mode_left == 0) begin
          mode      = traffic_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        send_word(pick_request(mode), pick_word());
        sent++;
        if (sent % DRAIN_EVERY == 0) wait_drained();
      end
      idle_for(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Ends a hung run; far beyond even an all-sort run on a full queue.
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
